FILE: hdl/phrl_pkg.sv
package phrl_pkg;

    localparam int HASH_BITS      = 32;
    localparam int SEC_BITS       = 14;
    localparam int KEY_BITS       = 15;
    localparam int RESULT_BITS    = 15;
    localparam int WIDX_BITS      = 10;
    localparam int MAP_BITS       = 64;
    localparam int CMD_BITS       = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 15;
    localparam int LANES          = 3;
    localparam int LANE_SEL_BITS  = 2;
    localparam int REM_STEP_BITS  = 4;
    localparam int REM_STAGES     = HASH_BITS / REM_STEP_BITS;
    localparam int PAIR_BITS      = 2;
    localparam int POS_BITS       = 5;
    localparam int COUNT_BITS     = 6;
    localparam int SUM3_BITS      = 4;
    localparam int PAIRS_PER_WORD = 32;
    localparam int WORD_BITS      = HASH_BITS - POS_BITS;
    localparam int MIN_KEYS       = 2;
    localparam int FEW_KEYS       = 24;
    localparam int LATENCY        = REM_STAGES + 3;

    localparam logic [MAP_BITS-1:0] MAP_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MAP_BITS-1:0] PAIR_LOW_MASK = 64'h5555_5555_5555_5555;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SECTION_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COUNT    = 1'b1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOOKUP       = 2'd0,
        CMD_MAP_WRITE    = 2'd1,
        CMD_OFFSET_WRITE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                 map_en;
        logic                 offset_en;
        logic [WIDX_BITS-1:0] index;
        logic [MAP_BITS-1:0]  data;
    } wr_cmd_t;

    typedef struct packed {
        logic [HASH_BITS-1:0] slot;
        logic [MAP_BITS-1:0]  map;
    } lane_hit_t;

    function automatic logic [PAIR_BITS-1:0] pair_at(input logic [MAP_BITS-1:0] map,
                                                     input logic [POS_BITS-1:0] pos);
        return map[{pos, 1'b0} +: PAIR_BITS];
    endfunction

    function automatic logic [LANE_SEL_BITS-1:0] mod3(input logic [SUM3_BITS-1:0] sum);
        logic [LANE_SEL_BITS-1:0] r;
        if (sum inside {4'd0, 4'd3, 4'd6, 4'd9})
            r = 2'd0;
        else if (sum inside {4'd1, 4'd4, 4'd7})
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] valid_below(input logic [MAP_BITS-1:0] map,
                                                          input logic [POS_BITS-1:0] pos);
        logic [MAP_BITS-1:0]   blk;
        logic [MAP_BITS-1:0]   full;
        logic [COUNT_BITS-1:0] cnt;
        blk  = map | (MAP_ONES << {pos, 1'b0});
        full = blk & (blk >> 1) & PAIR_LOW_MASK;
        cnt  = '0;
        for (int i = 0; i < PAIRS_PER_WORD; i++)
        begin
            cnt = cnt + COUNT_BITS'(full[2*i]);
        end
        return COUNT_BITS'(PAIRS_PER_WORD) - cnt;
    endfunction

endpackage

FILE: hdl/phrl_ram.sv
module phrl_ram #(
    parameter int WIDTH     = 64,
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/phrl_rem.sv
module phrl_rem (
    input  logic                           clk,
    input  logic [phrl_pkg::SEC_BITS-1:0]  section_size,
    input  logic [phrl_pkg::HASH_BITS-1:0] hash,
    output logic [phrl_pkg::HASH_BITS-1:0] rem
);
    import phrl_pkg::*;

    logic [SEC_BITS-1:0]  part_reg [REM_STAGES];
    logic [HASH_BITS-1:0] hash_reg [REM_STAGES];

    for (genvar g = 0; g < REM_STAGES; g++)
    begin : g_stage
        logic [SEC_BITS-1:0]  part_in;
        logic [SEC_BITS-1:0]  part_next;
        logic [HASH_BITS-1:0] hash_next;

        if (g == 0)
        begin : g_first
            assign part_in   = '0;
            assign hash_next = hash;
        end
        else
        begin : g_rest
            assign part_in   = part_reg[g-1];
            assign hash_next = hash_reg[g-1];
        end

        always_comb
        begin
            logic [SEC_BITS:0] acc;
            part_next = part_in;
            for (int b = 0; b < REM_STEP_BITS; b++)
            begin
                acc = {part_next, hash_next[HASH_BITS-1-g*REM_STEP_BITS-b]};
                if (acc >= {1'b0, section_size})
                begin
                    acc = acc - {1'b0, section_size};
                end
                part_next = acc[SEC_BITS-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            part_reg[g] <= part_next;
            hash_reg[g] <= hash_next;
        end
    end

    // zero section size: pass the hash word through unreduced
    assign rem = (section_size == '0) ? hash_reg[REM_STAGES-1]
                                      : HASH_BITS'(part_reg[REM_STAGES-1]);

endmodule

FILE: hdl/phrl_lane.sv
module phrl_lane #(
    parameter int MAP_WORDS = 1024,
    parameter int LANE      = 0
) (
    input  logic                           clk,
    input  logic [phrl_pkg::SEC_BITS-1:0]  section_size,
    input  logic [phrl_pkg::HASH_BITS-1:0] hash,
    input  phrl_pkg::wr_cmd_t              wr,
    output phrl_pkg::lane_hit_t            hit
);
    import phrl_pkg::*;

    localparam int ADDR_BITS = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [HASH_BITS-1:0] rem;
    logic [HASH_BITS-1:0] slot_next;
    logic [HASH_BITS-1:0] slot_reg;
    logic [WORD_BITS-1:0] word;
    logic                 in_range_next;
    logic                 in_range_reg;
    logic [HASH_BITS-1:0] widx_wide;
    logic                 map_we;
    logic [MAP_BITS-1:0]  map_q;

    phrl_rem u_rem (
        .clk          (clk),
        .section_size (section_size),
        .hash         (hash),
        .rem          (rem)
    );

    assign slot_next     = rem + HASH_BITS'(section_size) * HASH_BITS'(LANE);
    assign word          = slot_next[HASH_BITS-1:POS_BITS];
    assign in_range_next = {{POS_BITS{1'b0}}, word} < HASH_BITS'(MAP_WORDS);

    assign widx_wide = HASH_BITS'(wr.index);
    assign map_we    = wr.map_en && (widx_wide < HASH_BITS'(MAP_WORDS));

    phrl_ram #(
        .WIDTH     (MAP_BITS),
        .DEPTH     (MAP_WORDS),
        .ADDR_BITS (ADDR_BITS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (widx_wide[ADDR_BITS-1:0]),
        .wdata (wr.data),
        .raddr (word[ADDR_BITS-1:0]),
        .rdata (map_q)
    );

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        in_range_reg <= in_range_next;
    end

    assign hit.slot = slot_reg;
    assign hit.map  = in_range_reg ? map_q : '0;

endmodule

FILE: hdl/phrl_merge.sv
module phrl_merge #(
    parameter int MAP_WORDS   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid,
    input  phrl_pkg::lane_hit_t              hit [phrl_pkg::LANES],
    input  phrl_pkg::wr_cmd_t                wr,
    input  logic [phrl_pkg::KEY_BITS-1:0]    key_count,
    output logic                             done,
    output logic [phrl_pkg::RESULT_BITS-1:0] key_index
);
    import phrl_pkg::*;

    localparam int ADDR_BITS = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_BITS  = (OFFSET_BITS > RESULT_BITS) ? OFFSET_BITS : RESULT_BITS;

    logic [SUM3_BITS-1:0]     pair_sum;
    logic [LANE_SEL_BITS-1:0] sel;
    lane_hit_t                pick;
    logic [WORD_BITS-1:0]     word;
    logic [HASH_BITS-1:0]     widx_wide;
    logic                     offset_we;
    logic [OFFSET_BITS-1:0]   offset_q;

    logic                     valid_reg;
    logic                     in_range_reg;
    logic [POS_BITS-1:0]      pos_reg;
    logic [MAP_BITS-1:0]      map_reg;

    logic [OFFSET_BITS-1:0]   offset;
    logic [SUM_BITS-1:0]      total;
    logic [RESULT_BITS-1:0]   key_index_next;
    logic                     done_reg;
    logic [RESULT_BITS-1:0]   key_index_reg;

    always_comb
    begin
        pair_sum = SUM3_BITS'(pair_at(hit[0].map, hit[0].slot[POS_BITS-1:0]))
                 + SUM3_BITS'(pair_at(hit[1].map, hit[1].slot[POS_BITS-1:0]))
                 + SUM3_BITS'(pair_at(hit[2].map, hit[2].slot[POS_BITS-1:0]));
        sel = mod3(pair_sum);
        case (sel)
            2'd1:    pick = hit[1];
            2'd2:    pick = hit[2];
            default: pick = hit[0];
        endcase
    end

    assign word      = pick.slot[HASH_BITS-1:POS_BITS];
    assign widx_wide = HASH_BITS'(wr.index);
    assign offset_we = wr.offset_en && (widx_wide < HASH_BITS'(MAP_WORDS));

    phrl_ram #(
        .WIDTH     (OFFSET_BITS),
        .DEPTH     (MAP_WORDS),
        .ADDR_BITS (ADDR_BITS)
    ) u_offsets (
        .clk   (clk),
        .we    (offset_we),
        .waddr (widx_wide[ADDR_BITS-1:0]),
        .wdata (wr.data[OFFSET_BITS-1:0]),
        .raddr (word[ADDR_BITS-1:0]),
        .rdata (offset_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= {{POS_BITS{1'b0}}, word} < HASH_BITS'(MAP_WORDS);
        pos_reg      <= pick.slot[POS_BITS-1:0];
        map_reg      <= pick.map;
    end

    always_comb
    begin
        offset = (in_range_reg && (key_count > KEY_BITS'(FEW_KEYS))) ? offset_q : '0;
        total  = SUM_BITS'(offset) + SUM_BITS'(valid_below(map_reg, pos_reg));
        if (key_count < KEY_BITS'(MIN_KEYS))
            key_index_next = '0;
        else
            key_index_next = total[RESULT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_index_reg <= key_index_next;
    end

    assign done      = done_reg;
    assign key_index = key_index_reg;

endmodule

FILE: hdl/perfect_hash_rank_lookup.sv
// Minimal perfect hash lookup with rank over a three-section slot map.
// Input: pulse start with cmd and its fields; the word is taken at any
// clock edge with start high, busy is never raised. cmd lookup carries
// three hash words; map write and offset write load one table word at
// write_index from write_data. Unused commands are dropped.
// Output: done pulses for one cycle with key_index, once per lookup and
// in lookup order; writes give no result. The receiver cannot stall.
// Pipeline: the accepting edge leads to the done cycle through 8 remainder
// stages, one map read, one offset read and one output add.
// Throughput: one word per cycle; each hash word has its own lane with a
// private copy of the slot map, and writes are delayed to meet the read
// stages so lookups and writes take effect in acceptance order.
// Config: cfg_we with cfg_index and cfg_data sets section size or key
// count; write only while no lookup is in flight.
// Reset: clears the config registers and the lookup and write pipeline,
// not the data stages; table contents stay undefined until written.
module perfect_hash_rank_lookup #(
    parameter int MAP_WORDS   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [phrl_pkg::CMD_BITS-1:0]       cmd,
    input  logic [phrl_pkg::HASH_BITS-1:0]      hash_first,
    input  logic [phrl_pkg::HASH_BITS-1:0]      hash_second,
    input  logic [phrl_pkg::HASH_BITS-1:0]      hash_third,
    input  logic [phrl_pkg::WIDX_BITS-1:0]      write_index,
    input  logic [phrl_pkg::MAP_BITS-1:0]       write_data,
    output logic                                done,
    output logic [phrl_pkg::RESULT_BITS-1:0]    key_index,
    input  logic                                cfg_we,
    input  logic [phrl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [phrl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import phrl_pkg::*;

    logic                 accept;
    logic                 accept_lookup;
    logic [SEC_BITS-1:0]  section_size_reg;
    logic [KEY_BITS-1:0]  key_count_reg;
    logic                 lookup_reg [REM_STAGES+1];
    wr_cmd_t              wr_next;
    wr_cmd_t              wr_reg [REM_STAGES+1];
    logic [HASH_BITS-1:0] lane_hash [LANES];
    lane_hit_t            hit [LANES];

    assign busy          = 1'b0;
    assign accept        = start && !busy;
    assign accept_lookup = accept && (cmd == CMD_LOOKUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_size_reg <= '0;
            key_count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SECTION_SIZE: section_size_reg <= cfg_data[SEC_BITS-1:0];
                REG_KEY_COUNT:    key_count_reg    <= cfg_data[KEY_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        wr_next.map_en    = accept && (cmd == CMD_MAP_WRITE);
        wr_next.offset_en = accept && (cmd == CMD_OFFSET_WRITE);
        wr_next.index     = write_index;
        wr_next.data      = write_data;
    end

    // align writes with the read stages of the lookups
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= REM_STAGES; i++)
            begin
                lookup_reg[i] <= 1'b0;
                wr_reg[i]     <= '0;
            end
        end
        else
        begin
            lookup_reg[0] <= accept_lookup;
            wr_reg[0]     <= wr_next;
            for (int i = 1; i <= REM_STAGES; i++)
            begin
                lookup_reg[i] <= lookup_reg[i-1];
                wr_reg[i]     <= wr_reg[i-1];
            end
        end
    end

    assign lane_hash[0] = hash_first;
    assign lane_hash[1] = hash_second;
    assign lane_hash[2] = hash_third;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        phrl_lane #(
            .MAP_WORDS (MAP_WORDS),
            .LANE      (g)
        ) u_lane (
            .clk          (clk),
            .section_size (section_size_reg),
            .hash         (lane_hash[g]),
            .wr           (wr_reg[REM_STAGES-1]),
            .hit          (hit[g])
        );
    end

    phrl_merge #(
        .MAP_WORDS   (MAP_WORDS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (lookup_reg[REM_STAGES]),
        .hit       (hit),
        .wr        (wr_reg[REM_STAGES]),
        .key_count (key_count_reg),
        .done      (done),
        .key_index (key_index)
    );

    ap_done_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept_lookup, LATENCY))
        else $error("result without a lookup at the expected latency");

    ap_lookup_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept_lookup |-> ##LATENCY done)
        else $error("lookup lost in the pipeline");

    ap_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (key_count_reg < KEY_BITS'(MIN_KEYS))) |-> (key_index == '0))
        else $error("nonzero index with fewer than two keys");

    ap_few_keys_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (key_count_reg <= KEY_BITS'(FEW_KEYS)))
            |-> (key_index < RESULT_BITS'(PAIRS_PER_WORD)))
        else $error("index beyond one map word without rank offset");

endmodule
